>>> rtl/wsp_pkg.sv
// Package for the wiper speed pattern controller.
// Holds register indexes, speed codes, reset values and the drive pattern table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wsp_pkg;

    // Width of every configuration register and of the write data port.
    localparam int CFG_WIDTH       = 20;
    localparam int CFG_INDEX_WIDTH = 2;

    // Default width of the hold and dwell counters.
    localparam int COUNT_WIDTH_DEFAULT = 20;

    // Register reset values, already held to the register width.
    localparam logic [CFG_WIDTH-1:0] RST_LONG_PRESS   = CFG_WIDTH'(500000);
    localparam logic [CFG_WIDTH-1:0] RST_DWELL_SLOW   = CFG_WIDTH'(1000000);
    localparam logic [CFG_WIDTH-1:0] RST_DWELL_MEDIUM = CFG_WIDTH'(500000);
    localparam logic [CFG_WIDTH-1:0] RST_DWELL_FAST   = CFG_WIDTH'(100000);

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_LONG_PRESS   = 2'd0,
        CFG_DWELL_SLOW   = 2'd1,
        CFG_DWELL_MEDIUM = 2'd2,
        CFG_DWELL_FAST   = 2'd3
    } t_cfg_index;

    // Speed codes; zero means no speed has been selected yet.
    localparam logic [1:0] SPEED_NONE   = 2'd0;
    localparam logic [1:0] SPEED_FAST   = 2'd1;
    localparam logic [1:0] SPEED_MEDIUM = 2'd2;
    localparam logic [1:0] SPEED_SLOW   = 2'd3;

    // Drive word for each step of the wipe cycle.
    function automatic logic [3:0] f_pattern(input logic [1:0] step);
        logic [3:0] word;
        case (step)
            2'd0:    word = 4'h5;
            2'd1:    word = 4'h6;
            2'd2:    word = 4'hC;
            default: word = 4'h6;
        endcase
        return word;
    endfunction

endpackage

`default_nettype wire

>>> rtl/wiper_speed_pattern_controller.sv
// Wiper speed pattern controller top level: button press decoding and the
// drive pattern sequencer in one registered pass per tick.
// Depends on wsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel     Direction  Handshake           Payload
// tick in     input      i_valid / o_stall   i_button_level
// result out  output     o_valid / i_stall   o_drive_word, o_running, o_speed_level
// config      input      i_cfg_wr_en         i_cfg_index, i_cfg_data
//
// Each tick beat is taken in the cycle that it is accepted and its result beat is valid on the next
// cycle, so one beat per cycle flows while the output side does not stall.
// The figure is set by the single register stage that holds the controller state.
// The result of a beat is the state registers themselves, so a waiting result
// holds them and the input stalls only while that result is not taken.
// Reset (synchronous, active low) clears all state and loads the register defaults.

module wiper_speed_pattern_controller
    import wsp_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    // Tick channel.
    input  wire                        i_valid,
    output logic                       o_stall,
    input  wire                        i_button_level,
    // Result channel.
    output logic                       o_valid,
    input  wire                        i_stall,
    output logic [3:0]                 o_drive_word,
    output logic                       o_running,
    output logic [1:0]                 o_speed_level,
    // Configuration write port.
    input  wire                        i_cfg_wr_en,
    input  wire  [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  wire  [CFG_WIDTH-1:0]       i_cfg_data
);

    localparam logic [COUNT_WIDTH-1:0] CNT_ZERO = '0;
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE  = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

    // A register value is cut to the counter width; zero then acts as one.
    function automatic logic [COUNT_WIDTH-1:0] f_limit(input logic [CFG_WIDTH-1:0] v);
        logic [31:0] ext;
        ext = 32'(v);
        if (ext[COUNT_WIDTH-1:0] == CNT_ZERO) begin
            return CNT_ONE;
        end
        return ext[COUNT_WIDTH-1:0];
    endfunction

    // Configuration registers.
    logic [CFG_WIDTH-1:0] r_long_press;
    logic [CFG_WIDTH-1:0] r_dwell_slow;
    logic [CFG_WIDTH-1:0] r_dwell_medium;
    logic [CFG_WIDTH-1:0] r_dwell_fast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press   <= RST_LONG_PRESS;
            r_dwell_slow   <= RST_DWELL_SLOW;
            r_dwell_medium <= RST_DWELL_MEDIUM;
            r_dwell_fast   <= RST_DWELL_FAST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_LONG_PRESS:   r_long_press   <= i_cfg_data;
                CFG_DWELL_SLOW:   r_dwell_slow   <= i_cfg_data;
                CFG_DWELL_MEDIUM: r_dwell_medium <= i_cfg_data;
                CFG_DWELL_FAST:   r_dwell_fast   <= i_cfg_data;
            endcase
        end
    end

    // Controller state.
    logic                   r_button_prev, n_button_prev;
    logic                   r_holding,     n_holding;
    logic [COUNT_WIDTH-1:0] r_hold_count,  n_hold_count;
    logic                   r_run_on,      n_run_on;
    logic [1:0]             r_speed_sel,   n_speed_sel;
    logic [1:0]             r_cycle_speed, n_cycle_speed;
    logic [1:0]             r_step_index,  n_step_index;
    logic [COUNT_WIDTH-1:0] r_dwell_count, n_dwell_count;
    logic [3:0]             r_drive,       n_drive;
    logic                   r_out_valid;

    // A new tick is taken whenever the result stage is empty or being drained.
    logic accept;
    assign o_stall = r_out_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    always_comb begin
        logic                   rising;
        logic                   active;
        logic [COUNT_WIDTH-1:0] dwell_load;
        logic [COUNT_WIDTH-1:0] dwell_dec;

        n_button_prev = i_button_level;
        n_holding     = r_holding;
        n_hold_count  = r_hold_count;
        n_run_on      = r_run_on;
        n_speed_sel   = r_speed_sel;
        n_cycle_speed = r_cycle_speed;
        n_step_index  = r_step_index;
        n_dwell_count = r_dwell_count;
        n_drive       = r_drive;
        active        = 1'b1;
        dwell_load    = CNT_ONE;
        dwell_dec     = CNT_ZERO;

        // Button handling comes first in the tick.
        rising = i_button_level & ~r_button_prev;
        if (i_button_level && (r_holding || rising)) begin
            n_hold_count = rising ? CNT_ONE : (r_hold_count + CNT_ONE);
            n_holding    = 1'b1;
            if (n_hold_count >= f_limit(r_long_press)) begin
                // Long press: toggle run state, step the speed and restart the wipe cycle.
                n_holding     = 1'b0;
                n_hold_count  = CNT_ZERO;
                n_drive       = r_drive ^ 4'h4;
                n_run_on      = ~r_run_on;
                n_step_index  = 2'd0;
                n_dwell_count = CNT_ZERO;
                if (r_run_on) begin
                    n_drive = 4'h0;
                end
                n_speed_sel = (r_speed_sel == SPEED_SLOW) ? SPEED_FAST
                                                          : r_speed_sel + 2'd1;
            end
        end else if (!i_button_level && r_holding) begin
            // Short press ends on release with a speed step only.
            n_holding    = 1'b0;
            n_hold_count = CNT_ZERO;
            n_speed_sel  = (r_speed_sel == SPEED_SLOW) ? SPEED_FAST
                                                       : r_speed_sel + 2'd1;
        end

        // Pattern sequencer sees the state that the button logic left.
        if (n_run_on) begin
            if (n_dwell_count == CNT_ZERO) begin
                // The speed is latched only at the start of a wipe cycle.
                if (n_step_index == 2'd0) begin
                    n_cycle_speed = n_speed_sel;
                end
                case (n_cycle_speed)
                    SPEED_FAST:   dwell_load = f_limit(r_dwell_fast);
                    SPEED_MEDIUM: dwell_load = f_limit(r_dwell_medium);
                    SPEED_SLOW:   dwell_load = f_limit(r_dwell_slow);
                    default:      active     = 1'b0;
                endcase
                if (active) begin
                    n_dwell_count = dwell_load;
                    n_drive       = f_pattern(n_step_index);
                end
            end
            if (active) begin
                dwell_dec     = n_dwell_count - CNT_ONE;
                n_dwell_count = dwell_dec;
                if (dwell_dec == CNT_ZERO) begin
                    n_step_index = n_step_index + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_button_prev <= 1'b0;
            r_holding     <= 1'b0;
            r_hold_count  <= CNT_ZERO;
            r_run_on      <= 1'b0;
            r_speed_sel   <= SPEED_NONE;
            r_cycle_speed <= SPEED_NONE;
            r_step_index  <= 2'd0;
            r_dwell_count <= CNT_ZERO;
            r_drive       <= 4'h0;
            r_out_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_button_prev <= n_button_prev;
                r_holding     <= n_holding;
                r_hold_count  <= n_hold_count;
                r_run_on      <= n_run_on;
                r_speed_sel   <= n_speed_sel;
                r_cycle_speed <= n_cycle_speed;
                r_step_index  <= n_step_index;
                r_dwell_count <= n_dwell_count;
                r_drive       <= n_drive;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_drive_word  = r_drive;
    assign o_running     = r_run_on;
    assign o_speed_level = r_speed_sel;

endmodule

`default_nettype wire
